// ===== sv/qrs_preprocess_filter_chain_top_defines.svh =====
// Assertion macros shared by the filter chain RTL.
`ifndef QRS_PREPROCESS_FILTER_CHAIN_TOP_DEFINES_SVH
`define QRS_PREPROCESS_FILTER_CHAIN_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QPF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("filter chain check failed");

// The consequent must hold in the cycle after the antecedent.
`define QPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("filter chain check failed");

`endif

// ===== sv/qpf_pkg.sv =====
package qpf_pkg;

    // Delay line depths and the fixed shifts of the first three stages.
    localparam int unsigned LpDepth  = 12;
    localparam int unsigned HpDepth  = 32;
    localparam int unsigned SlDepth  = 4;
    localparam int unsigned LpShift  = 5;
    localparam int unsigned HpShift  = 5;
    localparam int unsigned SlShift  = 3;

    // The stage outputs that travel together down the pipeline.
    typedef struct packed {
        logic [31:0] lp;
        logic [31:0] hp;
        logic [31:0] sl;
        logic [31:0] sq;
    } t_res;

    // Load strobes for the four stages of the window mean unit.
    typedef struct packed {
        logic sum_ld;
        logic mag_ld;
        logic prod_ld;
        logic rem_ld;
    } t_wm_ctl;

    // Signed division by a power of two that truncates toward zero.
    function automatic logic [31:0] f_div_pow2(input logic [31:0] v, input int unsigned sh);
        logic [31:0] bias;
        begin
            bias = v[31] ? ((32'd1 << sh) - 32'd1) : 32'd0;
            return 32'($signed(v + bias) >>> sh);
        end
    endfunction

endpackage

// ===== sv/qpf_wmean.sv =====
module qpf_wmean
    import qpf_pkg::*;
#(
    parameter int unsigned WINDOW_LEN = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_wm_ctl     i_ctl,
    input  logic [31:0] i_sq,
    output logic [31:0] o_mean
);

    // Reciprocal of the window length, scaled by 2^32. With a magnitude of at most
    // 2^31 the scaled product undershoots the true quotient by less than one.
    localparam logic [63:0] WinRecip64 = (64'd1 << 32) / WINDOW_LEN;
    localparam logic [31:0] WinRecip   = WinRecip64[31:0];
    // The remainder after the estimate stays below twice the window length.
    localparam int unsigned RemW       = $clog2(2 * WINDOW_LEN);
    localparam logic [RemW-1:0] WinLenR = RemW'(WINDOW_LEN);

    logic [31:0] r_win [0:WINDOW_LEN-2];
    logic [31:0] r_acc;
    logic [31:0] r_sum;
    logic        r_neg7;
    logic [31:0] r_mag7;
    logic        r_neg8;
    logic [RemW-1:0] r_mag8;
    logic [31:0] r_q0;
    logic        r_neg9;
    logic [31:0] r_q9;
    logic [RemW-1:0] r_rem;

    logic [31:0] n_sum;
    logic [31:0] n_acc;
    logic [63:0] n_prod;
    logic [RemW-1:0] n_rem;
    logic [31:0] n_q;

    // Running sum of the stored squares plus the new one; the oldest drops out.
    assign n_sum = i_sq + r_acc;
    assign n_acc = n_sum - r_win[WINDOW_LEN-2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 32'd0;
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                r_win[i] <= 32'd0;
            end
        end else if (i_ctl.sum_ld) begin
            r_acc    <= n_acc;
            r_win[0] <= i_sq;
            for (int i = WINDOW_LEN - 2; i > 0; i--) begin
                r_win[i] <= r_win[i-1];
            end
        end
    end

    // Quotient estimate by reciprocal multiplication, then a one-step correction.
    assign n_prod = {32'd0, r_mag7} * {32'd0, WinRecip};
    assign n_rem  = r_mag8 - RemW'(r_q0[RemW-1:0] * WinLenR);

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_ld) begin
            r_sum <= n_sum;
        end
        if (i_ctl.mag_ld) begin
            r_neg7 <= r_sum[31];
            r_mag7 <= r_sum[31] ? (32'd0 - r_sum) : r_sum;
        end
        if (i_ctl.prod_ld) begin
            r_neg8 <= r_neg7;
            r_mag8 <= r_mag7[RemW-1:0];
            r_q0   <= n_prod[63:32];
        end
        if (i_ctl.rem_ld) begin
            r_neg9 <= r_neg8;
            r_q9   <= r_q0;
            r_rem  <= n_rem;
        end
    end

    // Final quotient with the sign restored.
    assign n_q    = r_q9 + ((r_rem >= WinLenR) ? 32'd1 : 32'd0);
    assign o_mean = r_neg9 ? (32'd0 - n_q) : n_q;

endmodule

// ===== sv/qrs_preprocess_filter_chain_top.sv =====
// QRS pre-processing chain: each input sample runs through a recursive low-pass,
// a recursive high-pass, a five-point derivative, a squarer and a moving-window
// mean, and every sample yields one result carrying all five stage outputs. The
// block is a ten-stage pipeline that takes one sample per clock cycle while no
// stall holds it. A result is presented from the last stage register; the depth
// is set by the squarer multiplier and by the window mean, which divides by the
// window length through a reciprocal multiplier and a correction step. A stage
// stalls only when the stage after it is full and stalled itself, so a held result
// does not stop samples entering until the pipeline has filled. All filter state
// resets to zero.
`include "qrs_preprocess_filter_chain_top_defines.svh"

module qrs_preprocess_filter_chain_top
    import qpf_pkg::*;
#(
    parameter int unsigned WINDOW_LEN = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_sample,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_lowpass_out,
    output logic signed [31:0] o_highpass_out,
    output logic signed [31:0] o_slope_out,
    output logic signed [31:0] o_squared_out,
    output logic signed [31:0] o_window_mean_out
);

    localparam int unsigned NumStg = 10;

    logic [NumStg:1] r_vld;
    logic [NumStg:1] en;
    logic [NumStg:1] vin;
    logic [NumStg:1] go;

    logic [15:0] r_x;
    logic [15:0] r_xd [0:LpDepth-1];
    logic [31:0] r_lp1;
    logic [31:0] r_lp2;
    logic [31:0] r_hd [0:HpDepth-1];
    logic [31:0] r_hp1;
    logic [31:0] r_sd [0:SlDepth-1];
    t_res        r_res [2:NumStg];
    logic [31:0] r_mean;

    logic [31:0] n_lp_in;
    logic [31:0] n_lp;
    logic [31:0] n_hp;
    logic [31:0] n_sl_in;
    logic [31:0] n_sl;
    logic [31:0] n_sq;
    logic [31:0] wm_mean;
    t_wm_ctl     wm_ctl;

    // Per-stage flow control: a stage moves when it is empty or its successor moves.
    always_comb begin
        en[NumStg] = !r_vld[NumStg] || i_out_ready;
        for (int k = NumStg - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        vin[1] = i_in_valid;
        for (int k = 2; k <= NumStg; k++) begin
            vin[k] = r_vld[k-1];
        end
        go = en & vin;
    end

    assign o_in_ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NumStg; k++) begin
                if (en[k]) begin
                    r_vld[k] <= vin[k];
                end
            end
        end
    end

    // Low-pass: recursive second-order section on the raw samples.
    assign n_lp_in = 32'($signed(r_x)) - (32'($signed(r_xd[5])) << 1)
                   + 32'($signed(r_xd[11]));
    assign n_lp    = (r_lp1 << 1) - r_lp2 + f_div_pow2(n_lp_in, LpShift);

    // High-pass: recursive section on the low-pass outputs.
    assign n_hp = r_hp1 - f_div_pow2(r_res[2].lp, HpShift) + r_hd[15] - r_hd[16]
                + f_div_pow2(r_hd[31], HpShift);

    // Five-point derivative on the high-pass outputs.
    assign n_sl_in = (r_res[3].hp << 1) + r_sd[0] - r_sd[2] - (r_sd[3] << 1);
    assign n_sl    = f_div_pow2(n_sl_in, SlShift);

    // Squarer keeps the low word only.
    assign n_sq = r_res[4].sl * r_res[4].sl;

    // Filter state advances only as a sample passes the stage that owns it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp1 <= 32'd0;
            r_lp2 <= 32'd0;
            r_hp1 <= 32'd0;
            for (int i = 0; i < LpDepth; i++) begin
                r_xd[i] <= 16'd0;
            end
            for (int i = 0; i < HpDepth; i++) begin
                r_hd[i] <= 32'd0;
            end
            for (int i = 0; i < SlDepth; i++) begin
                r_sd[i] <= 32'd0;
            end
        end else begin
            if (go[2]) begin
                r_lp1   <= n_lp;
                r_lp2   <= r_lp1;
                r_xd[0] <= r_x;
                for (int i = LpDepth - 1; i > 0; i--) begin
                    r_xd[i] <= r_xd[i-1];
                end
            end
            if (go[3]) begin
                r_hp1   <= n_hp;
                r_hd[0] <= r_res[2].lp;
                for (int i = HpDepth - 1; i > 0; i--) begin
                    r_hd[i] <= r_hd[i-1];
                end
            end
            if (go[4]) begin
                r_sd[0] <= r_res[3].hp;
                for (int i = SlDepth - 1; i > 0; i--) begin
                    r_sd[i] <= r_sd[i-1];
                end
            end
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (go[1]) begin
            r_x <= i_sample;
        end
        if (go[2]) begin
            r_res[2] <= '{lp: n_lp, hp: 32'd0, sl: 32'd0, sq: 32'd0};
        end
        if (go[3]) begin
            r_res[3] <= '{lp: r_res[2].lp, hp: n_hp, sl: r_res[2].sl, sq: r_res[2].sq};
        end
        if (go[4]) begin
            r_res[4] <= '{lp: r_res[3].lp, hp: r_res[3].hp, sl: n_sl, sq: r_res[3].sq};
        end
        if (go[5]) begin
            r_res[5] <= '{lp: r_res[4].lp, hp: r_res[4].hp, sl: r_res[4].sl, sq: n_sq};
        end
        for (int k = 6; k <= NumStg; k++) begin
            if (go[k]) begin
                r_res[k] <= r_res[k-1];
            end
        end
        if (go[NumStg]) begin
            r_mean <= wm_mean;
        end
    end

    // Moving-window mean over the squared values.
    assign wm_ctl = '{sum_ld: go[6], mag_ld: go[7], prod_ld: go[8], rem_ld: go[9]};

    qpf_wmean #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_wmean (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (wm_ctl),
        .i_sq   (r_res[5].sq),
        .o_mean (wm_mean)
    );

    assign o_out_valid       = r_vld[NumStg];
    assign o_lowpass_out     = $signed(r_res[NumStg].lp);
    assign o_highpass_out    = $signed(r_res[NumStg].hp);
    assign o_slope_out       = $signed(r_res[NumStg].sl);
    assign o_squared_out     = $signed(r_res[NumStg].sq);
    assign o_window_mean_out = $signed(r_mean);

    // An empty front stage always takes a request.
    `QPF_ASSERT_NOW(a_front_empty_ready, i_clk, i_rst_n, !r_vld[1], o_in_ready)
    // An accepted request always lands in the front stage.
    `QPF_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_in_valid && o_in_ready, r_vld[1])
    // A full pipeline with a stalled output refuses new requests.
    `QPF_ASSERT_NOW(a_full_blocks, i_clk, i_rst_n, (&r_vld) && !i_out_ready, !o_in_ready)

endmodule

// ===== tb/qrs_preprocess_filter_chain_top_tb.sv =====
`timescale 1ns / 1ps

module qrs_preprocess_filter_chain_top_tb;
    import qpf_pkg::*;

    localparam int unsigned WINDOW_LEN    = 30;
    localparam int unsigned RANDOM_ITEMS  = 700;
    localparam int unsigned DRAIN_CYCLES  = 30;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    // The five stage outputs that one request produces.
    typedef struct {
        logic [31:0] lowpass;
        logic [31:0] highpass;
        logic [31:0] slope;
        logic [31:0] squared;
        logic [31:0] window_mean;
    } t_filter_outputs;

    // Ways in which the result side holds off.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    // Scoreboard: runs its own copy of the filter chain and checks results in order.
    class chain_scoreboard;
        int unsigned     errors;
        t_filter_outputs expected_outputs[$];

        logic [31:0] lp_y1;
        logic [31:0] lp_y2;
        logic [15:0] raw_hist[LpDepth];
        logic [31:0] hp_y1;
        logic [31:0] lp_hist[HpDepth];
        logic [31:0] hp_hist[SlDepth];
        logic [31:0] sq_hist[WINDOW_LEN - 1];

        function new();
            errors = 0;
            lp_y1  = '0;
            lp_y2  = '0;
            hp_y1  = '0;
            foreach (raw_hist[i]) raw_hist[i] = '0;
            foreach (lp_hist[i]) lp_hist[i] = '0;
            foreach (hp_hist[i]) hp_hist[i] = '0;
            foreach (sq_hist[i]) sq_hist[i] = '0;
        endfunction

        function logic [31:0] sign_extend16(logic [15:0] v);
            return {{16{v[15]}}, v};
        endfunction

        // Signed division truncating toward zero; the most negative value is taken as a magnitude of 2^31.
        function logic [31:0] quot_toward_zero(logic [31:0] v, logic [31:0] d);
            logic [31:0] mag;
            logic [31:0] q;
            mag = v[31] ? (32'd0 - v) : v;
            q   = mag / d;
            return v[31] ? (32'd0 - q) : q;
        endfunction

        task flag_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        function int unsigned pending();
            return expected_outputs.size();
        endfunction

        // Advance the chain by one accepted sample and queue what it should produce.
        task note_sample(logic [15:0] sample);
            logic [31:0] x;
            logic [31:0] lp;
            logic [31:0] hp;
            logic [31:0] sl;
            logic [31:0] sq;
            logic [31:0] sum;
            t_filter_outputs want;

            // Recursive low-pass.
            x  = sign_extend16(sample);
            lp = 32'd2 * lp_y1 - lp_y2
               + quot_toward_zero(x - 32'd2 * sign_extend16(raw_hist[5])
                                  + sign_extend16(raw_hist[11]), 32'd32);
            lp_y2 = lp_y1;
            lp_y1 = lp;
            for (int i = LpDepth - 1; i > 0; i--) raw_hist[i] = raw_hist[i - 1];
            raw_hist[0] = sample;

            // Recursive high-pass over the low-pass history.
            hp = hp_y1 - quot_toward_zero(lp, 32'd32) + lp_hist[15] - lp_hist[16]
               + quot_toward_zero(lp_hist[31], 32'd32);
            hp_y1 = hp;
            for (int i = HpDepth - 1; i > 0; i--) lp_hist[i] = lp_hist[i - 1];
            lp_hist[0] = lp;

            // Five-point derivative, then the square kept to 32 bits.
            sl = quot_toward_zero(32'd2 * hp + hp_hist[0] - hp_hist[2]
                                  - 32'd2 * hp_hist[3], 32'd8);
            for (int i = SlDepth - 1; i > 0; i--) hp_hist[i] = hp_hist[i - 1];
            hp_hist[0] = hp;
            sq = sl * sl;

            // Window sum wraps before the division.
            sum = sq;
            foreach (sq_hist[i]) sum += sq_hist[i];
            for (int i = WINDOW_LEN - 2; i > 0; i--) sq_hist[i] = sq_hist[i - 1];
            sq_hist[0] = sq;

            want.lowpass     = lp;
            want.highpass    = hp;
            want.slope       = sl;
            want.squared     = sq;
            want.window_mean = quot_toward_zero(sum, WINDOW_LEN);
            expected_outputs.push_back(want);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                flag_mismatch($sformatf("%s got %h expected %h", name, got, want));
        endtask

        task check_result(t_filter_outputs got);
            t_filter_outputs want;
            if (expected_outputs.size() == 0) begin
                flag_mismatch("result arrived with nothing expected");
            end else begin
                want = expected_outputs.pop_front();
                compare_field("lowpass_out", got.lowpass, want.lowpass);
                compare_field("highpass_out", got.highpass, want.highpass);
                compare_field("slope_out", got.slope, want.slope);
                compare_field("squared_out", got.squared, want.squared);
                compare_field("window_mean_out", got.window_mean, want.window_mean);
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic signed [15:0] i_sample    = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_lowpass_out;
    logic signed [31:0] o_highpass_out;
    logic signed [31:0] o_slope_out;
    logic signed [31:0] o_squared_out;
    logic signed [31:0] o_window_mean_out;

    chain_scoreboard sb = new();
    logic [15:0]     sample_stream[$];
    t_filter_outputs rx_item;
    t_rx_mode        rx_mode      = RX_ALWAYS;
    int unsigned     rx_mode_left = 0;
    int unsigned     cycle_count  = 0;
    int unsigned     pick;
    int unsigned     run_len;
    logic [15:0]     level;

    qrs_preprocess_filter_chain_top #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_lowpass_out    (o_lowpass_out),
        .o_highpass_out   (o_highpass_out),
        .o_slope_out      (o_slope_out),
        .o_squared_out    (o_squared_out),
        .o_window_mean_out(o_window_mean_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop on a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: check each accepted request, then pick the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            rx_item.lowpass     = o_lowpass_out;
            rx_item.highpass    = o_highpass_out;
            rx_item.slope       = o_slope_out;
            rx_item.squared     = o_squared_out;
            rx_item.window_mean = o_window_mean_out;
            sb.check_result(rx_item);
        end
        if (rx_mode_left == 0) begin
            rx_mode      <= t_rx_mode'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(20, 120);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS:   i_out_ready <= 1'b1;
            RX_RANDOM:   i_out_ready <= ($urandom_range(0, 99) < 60);
            RX_PERIODIC: i_out_ready <= (cycle_count % 5 == 0);
            default:     i_out_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Sender: bursts of back-to-back requests separated by random gaps.
    task automatic send_samples();
        int unsigned burst_left;
        int unsigned gap;
        burst_left = 0;
        foreach (sample_stream[k]) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_in_valid <= 1'b1;
            i_sample   <= sample_stream[k];
            do @(posedge i_clk); while (!o_in_ready);
            sb.note_sample(sample_stream[k]);
            burst_left--;
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        // Directed start: zero, the field extremes, near-extremes and full swings.
        sample_stream.push_back(16'h0000);
        sample_stream.push_back(16'h7fff);
        sample_stream.push_back(16'h8000);
        sample_stream.push_back(16'hffff);
        sample_stream.push_back(16'h0001);
        sample_stream.push_back(16'h4000);
        sample_stream.push_back(16'hbfff);
        sample_stream.push_back(16'h001f);
        sample_stream.push_back(16'hffe1);
        for (int i = 0; i < 8; i++) sample_stream.push_back((i % 2) ? 16'h8000 : 16'h7fff);
        for (int i = 0; i < 8; i++) sample_stream.push_back(16'h7fff);

        // Random part: full-range noise, small signal-like values, and runs at the rails
        // that drive the recursive stages and the window sum into wrap-around.
        while (sample_stream.size() < RANDOM_ITEMS + 25) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                sample_stream.push_back(16'($urandom_range(0, 65535)));
            end else if (pick < 8) begin
                sample_stream.push_back(16'(int'($urandom_range(0, 600)) - 300));
            end else begin
                level   = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                run_len = $urandom_range(4, 12);
                repeat (run_len) sample_stream.push_back(level);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_samples();

        // Drain everything outstanding, then wait out the drain period for strays.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) sb.flag_mismatch("expected results left over");
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
